// ----- hdl/mbn_pkg.sv -----
`timescale 1ns / 1ps
// Package: widths, codes and item types shared by the mesh bounding-box normaliser.
package mbn_pkg;

   // Fixed-point format of coordinates and scale
   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int SPAN_W    = 33;
   localparam int PROD_W    = 2 * COORD_W;

   // Divider sizing: 10 * span needs 36 bits; the dividend covers both
   // the scale numerator and the shifted denormalise magnitude.
   localparam int DEN_W      = 36;
   localparam int DIV_W_FIN  = 2 * FRAC_BITS + 6;
   localparam int DIV_W_DEN  = FRAC_BITS + COORD_W;
   localparam int DIV_W_AB   = (DIV_W_FIN > DIV_W_DEN) ? DIV_W_FIN : DIV_W_DEN;
   localparam int DIV_W      = (DIV_W_AB > DEN_W + 1) ? DIV_W_AB : DEN_W + 1;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

   // scale = 1.9 / span, done as 19 * 2^(2F) / (10 * span)
   localparam logic [DIV_W-1:0] SCALE_NUM = DIV_W'(19) << (2 * FRAC_BITS);

   localparam logic [COORD_W-1:0] SCALE_SAT = {COORD_W{1'b1}};
   localparam logic signed [COORD_W-1:0] Q_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // Operation codes
   localparam logic [1:0] OP_MEASURE   = 2'd0;
   localparam logic [1:0] OP_FINALIZE  = 2'd1;
   localparam logic [1:0] OP_TRANSFORM = 2'd2;
   localparam logic [1:0] OP_DENORM    = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_FIN    = 2'd0;
   localparam logic [1:0] KIND_XFORM  = 2'd1;
   localparam logic [1:0] KIND_DENORM = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_EMPTY     = 2'd1;
   localparam logic [1:0] STAT_ZERO_SPAN = 2'd2;
   localparam logic [1:0] STAT_NOT_FIN   = 2'd3;

   // Axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [COORD_W-1:0] x_in;
      logic signed [COORD_W-1:0] y_in;
      logic signed [COORD_W-1:0] z_in;
      logic [1:0]                axis;
   } req_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic [COORD_W-1:0]        scale_out;
      logic [1:0]                status;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         axis;
      logic               neg;
      logic [COORD_W-1:0] mag;
      logic [COORD_W-1:0] scale;
   } mul_req_type;

   typedef struct packed {
      logic                      valid;
      logic [1:0]                axis;
      logic signed [COORD_W-1:0] value;
   } mul_rsp_type;

endpackage

// ----- hdl/mbn_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by finalise and denormalise.
module mbn_div (
   input  logic                clock,
   input  logic                reset,
   input  mbn_pkg::div_req_type div_req,
   output mbn_pkg::div_rsp_type div_rsp
);
   import mbn_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- hdl/mbn_mul.sv -----
`timescale 1ns / 1ps
// Shared 32x32 scale multiplier with round-to-nearest and signed saturation.
module mbn_mul (
   input  logic                clock,
   input  logic                reset,
   input  mbn_pkg::mul_req_type mul_req,
   output mbn_pkg::mul_rsp_type mul_rsp
);
   import mbn_pkg::*;

   localparam int Q_W = PROD_W - FRAC_BITS + 1;

   logic              p_valid_ff;
   logic [1:0]        p_axis_ff;
   logic              p_neg_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;

   logic                      r_valid_ff;
   logic [1:0]                r_axis_ff;
   logic signed [COORD_W-1:0] res_ff, res_in;

   logic [Q_W-1:0]     q;
   logic [COORD_W-1:0] q_clip;

   always_comb begin
      prod_in = PROD_W'(mul_req.mag) * PROD_W'(mul_req.scale);
      q = Q_W'(prod_ff[PROD_W-1:FRAC_BITS]) + Q_W'(prod_ff[FRAC_BITS-1]);
      // magnitude clamps at 2^31 before the sign goes back on
      q_clip = (q > Q_W'({1'b1, {(COORD_W-1){1'b0}}})) ?
               {1'b1, {(COORD_W-1){1'b0}}} : q[COORD_W-1:0];
      if (p_neg_ff) begin
         res_in = -$signed(q_clip);
      end else if (q_clip[COORD_W-1]) begin
         res_in = Q_MAX;
      end else begin
         res_in = $signed(q_clip);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= mul_req.valid;
         r_valid_ff <= p_valid_ff;
      end
      p_axis_ff <= mul_req.axis;
      p_neg_ff  <= mul_req.neg;
      prod_ff   <= prod_in;
      r_axis_ff <= p_axis_ff;
      res_ff    <= res_in;
   end

   assign mul_rsp.valid = r_valid_ff;
   assign mul_rsp.axis  = r_axis_ff;
   assign mul_rsp.value = res_ff;

endmodule

// ----- hdl/mesh_bbox_normalizer.sv -----
`timescale 1ns / 1ps
// Top level: mesh bounding-box normaliser, sequencer around a shared multiplier and divider.
//
//   channel  dir  ports                          payload
//   req      in   req_valid, req_stall (out)     mbn_pkg::req_type (op, x/y/z_in, axis)
//   rsp      out  rsp_valid, rsp_stall (in)      mbn_pkg::rsp_type (kind, out_x/y/z,
//                                                scale_out, status)
//
// One item at a time; req_stall is high from acceptance until the item is done,
// with any result parked in the output register. A transform makes three issues
// into the 2-stage multiplier; finalise and denormalise use the bit-serial divider
// (DIV_W = 48 at 16 fraction bits); early-out cases skip the multiplier or divider.
// Reset is synchronous and active high; no clearing pass is needed.
// The output register frees the core: a stalled result holds while the next
// item is already being worked on, and only a second result waits for it.
module mesh_bbox_normalizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mbn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mbn_pkg::rsp_type rsp_data
);
   import mbn_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MEAS   = 3'd1;
   localparam logic [2:0] ST_FIN    = 3'd2;
   localparam logic [2:0] ST_FSCALE = 3'd3;
   localparam logic [2:0] ST_FDIV   = 3'd4;
   localparam logic [2:0] ST_XFORM  = 3'd5;
   localparam logic [2:0] ST_XWAIT  = 3'd6;
   localparam logic [2:0] ST_DDIV   = 3'd7;

   // ST_OUT shares no code: result hand-off is its own state below
   localparam logic [3:0] ST_NONE = 4'd0;

   logic [3:0] state_ff, state_in;
   localparam logic [3:0] S_IDLE   = {1'b0, ST_IDLE};
   localparam logic [3:0] S_MEAS   = {1'b0, ST_MEAS};
   localparam logic [3:0] S_FIN    = {1'b0, ST_FIN};
   localparam logic [3:0] S_FSCALE = {1'b0, ST_FSCALE};
   localparam logic [3:0] S_FDIV   = {1'b0, ST_FDIV};
   localparam logic [3:0] S_XFORM  = {1'b0, ST_XFORM};
   localparam logic [3:0] S_XWAIT  = {1'b0, ST_XWAIT};
   localparam logic [3:0] S_DDIV   = {1'b0, ST_DDIV};
   localparam logic [3:0] S_OUT    = 4'd8;

   logic [1:0] ax_ff, ax_in;
   req_type    item_ff, item_in;
   logic       seen_ff, seen_in;
   logic       fin_ff, fin_in;

   logic signed [COORD_W-1:0] box_min_ff [0:2];
   logic signed [COORD_W-1:0] box_min_in [0:2];
   logic signed [COORD_W-1:0] box_max_ff [0:2];
   logic signed [COORD_W-1:0] box_max_in [0:2];
   logic signed [COORD_W-1:0] center_ff  [0:2];
   logic signed [COORD_W-1:0] center_in  [0:2];

   logic [COORD_W-1:0] scale_ff, scale_in;
   logic [SPAN_W-1:0]  span_ff, span_in;

   rsp_type res_ff, res_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   div_req_type div_req;
   div_rsp_type div_rsp;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   // per-axis views
   logic signed [COORD_W-1:0] coord;
   logic signed [COORD_W-1:0] cur_min, cur_max, cur_center;
   logic signed [SPAN_W-1:0]  box_sum;
   logic [SPAN_W-1:0]         span_k;
   logic signed [SPAN_W-1:0]  delta;
   logic [SPAN_W-1:0]         delta_mag;

   // divider operands
   logic [COORD_W-1:0] den_mag;
   logic [DEN_W-1:0]   fin_den;
   logic [DIV_W-1:0]   fin_dividend;
   logic [DIV_W-1:0]   dn_dividend;
   logic [1:0]         req_axis;

   // denormalise result
   logic                      q_big;
   logic signed [COORD_W+2:0] q_signed;
   logic signed [COORD_W+2:0] dn_sum;
   logic signed [COORD_W-1:0] dn_result;
   logic signed [COORD_W-1:0] dn_zero_scale;
   logic [COORD_W-1:0]        scale_q;

   mbn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   mbn_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      case (ax_ff)
         AXIS_X:  coord = item_ff.x_in;
         AXIS_Y:  coord = item_ff.y_in;
         default: coord = item_ff.z_in;
      endcase
      cur_min    = box_min_ff[ax_ff];
      cur_max    = box_max_ff[ax_ff];
      cur_center = center_ff[ax_ff];

      // floor((min + max) / 2) is the top 32 bits of the 33-bit sum
      box_sum = {cur_min[COORD_W-1], cur_min} + {cur_max[COORD_W-1], cur_max};
      span_k  = {cur_max[COORD_W-1], cur_max} - {cur_min[COORD_W-1], cur_min};

      // transform operand: v - center, split into sign and magnitude
      delta     = {coord[COORD_W-1], coord} - {cur_center[COORD_W-1], cur_center};
      delta_mag = delta[SPAN_W-1] ? -delta : delta;

      mul_req.valid = (state_ff == S_XFORM);
      mul_req.axis  = ax_ff;
      mul_req.neg   = delta[SPAN_W-1];
      mul_req.mag   = delta_mag[COORD_W-1:0];
      mul_req.scale = scale_ff;

      // 10 * span by shift and add
      fin_den      = DEN_W'({span_ff, 3'b000}) + DEN_W'({span_ff, 1'b0});
      fin_dividend = SCALE_NUM + DIV_W'(fin_den >> 1);
      den_mag      = req_data.x_in[COORD_W-1] ? -req_data.x_in : req_data.x_in;
      dn_dividend  = (DIV_W'(den_mag) << FRAC_BITS) + DIV_W'(scale_ff >> 1);
      req_axis     = (req_data.axis > AXIS_Z) ? AXIS_Z : req_data.axis;

      scale_q = (|div_rsp.quotient[DIV_W-1:COORD_W]) ? SCALE_SAT :
                div_rsp.quotient[COORD_W-1:0];

      // coord / scale + center, saturated; a quotient of 2^33 or more saturates outright
      q_big    = |div_rsp.quotient[DIV_W-1:COORD_W+1];
      q_signed = $signed({2'b00, div_rsp.quotient[COORD_W:0]});
      if (item_ff.x_in[COORD_W-1]) begin
         q_signed = -q_signed;
      end
      dn_sum = q_signed + (COORD_W+3)'(cur_center);
      if (q_big) begin
         dn_result = item_ff.x_in[COORD_W-1] ? Q_MIN : Q_MAX;
      end else if (dn_sum > (COORD_W+3)'(Q_MAX)) begin
         dn_result = Q_MAX;
      end else if (dn_sum < (COORD_W+3)'(Q_MIN)) begin
         dn_result = Q_MIN;
      end else begin
         dn_result = dn_sum[COORD_W-1:0];
      end

      // zero scale: infinite quotient, sign of the coordinate decides
      if (item_ff.x_in > 0) begin
         dn_zero_scale = Q_MAX;
      end else if (item_ff.x_in < 0) begin
         dn_zero_scale = Q_MIN;
      end else begin
         dn_zero_scale = cur_center;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      item_in      = item_ff;
      seen_in      = seen_ff;
      fin_in       = fin_ff;
      scale_in     = scale_ff;
      span_in      = span_ff;
      res_in       = res_ff;
      box_min_in   = box_min_ff;
      box_max_in   = box_max_ff;
      center_in    = center_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      div_req.dividend = (state_ff == S_IDLE) ? dn_dividend : fin_dividend;
      div_req.divisor  = (state_ff == S_IDLE) ? DEN_W'(scale_ff) : fin_den;
      div_req.start    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // multiplier results land by axis tag
      if (mul_rsp.valid) begin
         case (mul_rsp.axis)
            AXIS_X:  res_in.out_x = mul_rsp.value;
            AXIS_Y:  res_in.out_y = mul_rsp.value;
            default: res_in.out_z = mul_rsp.value;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in          = req_data;
               ax_in            = AXIS_X;
               res_in.out_x     = '0;
               res_in.out_y     = '0;
               res_in.out_z     = '0;
               res_in.scale_out = scale_ff;
               res_in.status    = STAT_OK;
               unique case (req_data.op)
                  OP_MEASURE: begin
                     state_in = S_MEAS;
                  end
                  OP_FINALIZE: begin
                     res_in.kind = KIND_FIN;
                     state_in    = S_FIN;
                  end
                  OP_TRANSFORM: begin
                     res_in.kind = KIND_XFORM;
                     if (!fin_ff) begin
                        res_in.scale_out = '0;
                        res_in.status    = STAT_NOT_FIN;
                        state_in         = S_OUT;
                     end else begin
                        state_in = S_XFORM;
                     end
                  end
                  default: begin
                     res_in.kind = KIND_DENORM;
                     ax_in       = req_axis;
                     if (!fin_ff) begin
                        res_in.scale_out = '0;
                        res_in.status    = STAT_NOT_FIN;
                        state_in         = S_OUT;
                     end else begin
                        div_req.start = (scale_ff != '0);
                        state_in      = S_DDIV;
                     end
                  end
               endcase
            end
         end

         // one axis per cycle through the min/max compare
         S_MEAS: begin
            if (!seen_ff || coord < cur_min) begin
               box_min_in[ax_ff] = coord;
            end
            if (!seen_ff || coord > cur_max) begin
               box_max_in[ax_ff] = coord;
            end
            if (ax_ff == AXIS_Z) begin
               seen_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end

         // centres per axis; largest span over x and y only
         S_FIN: begin
            center_in[ax_ff] = seen_ff ? box_sum[SPAN_W-1:1] : '0;
            if (!seen_ff) begin
               span_in = '0;
            end else if (ax_ff == AXIS_X) begin
               span_in = span_k;
            end else if (ax_ff == AXIS_Y && span_k > span_ff) begin
               span_in = span_k;
            end
            if (ax_ff == AXIS_Z) begin
               state_in = S_FSCALE;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end

         S_FSCALE: begin
            seen_in      = 1'b0;
            fin_in       = 1'b1;
            box_min_in   = '{default: '0};
            box_max_in   = '{default: '0};
            res_in.out_x = center_ff[0];
            res_in.out_y = center_ff[1];
            res_in.out_z = center_ff[2];
            if (!seen_ff) begin
               scale_in         = SCALE_SAT;
               res_in.scale_out = SCALE_SAT;
               res_in.status    = STAT_EMPTY;
               state_in         = S_OUT;
            end else if (span_ff == '0) begin
               scale_in         = SCALE_SAT;
               res_in.scale_out = SCALE_SAT;
               res_in.status    = STAT_ZERO_SPAN;
               state_in         = S_OUT;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_FDIV;
            end
         end

         S_FDIV: begin
            if (div_rsp.done) begin
               scale_in         = scale_q;
               res_in.scale_out = scale_q;
               res_in.status    = STAT_OK;
               state_in         = S_OUT;
            end
         end

         // issue x, y, z into the multiplier on consecutive cycles
         S_XFORM: begin
            if (ax_ff == AXIS_Z) begin
               state_in = S_XWAIT;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end

         S_XWAIT: begin
            if (mul_rsp.valid && mul_rsp.axis == AXIS_Z) begin
               state_in = S_OUT;
            end
         end

         S_DDIV: begin
            if (scale_ff == '0) begin
               res_in.out_x = dn_zero_scale;
               state_in     = S_OUT;
            end else if (div_rsp.done) begin
               res_in.out_x = dn_result;
               state_in     = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ax_ff        <= AXIS_X;
         seen_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scale_ff     <= '0;
         span_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ax_ff        <= ax_in;
         seen_ff      <= seen_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
         scale_ff     <= scale_in;
         span_ff      <= span_in;
      end
      item_ff     <= item_in;
      box_min_ff  <= box_min_in;
      box_max_ff  <= box_max_in;
      center_ff   <= center_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // divider answers only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_FDIV || state_ff == S_DDIV))
      else $error("divider result outside a divide wait");

   // multiplier results only during a transform
   assert property (@(posedge clock) disable iff (reset)
      mul_rsp.valid |-> (state_ff == S_XFORM || state_ff == S_XWAIT))
      else $error("multiplier result outside a transform");

   // a finalise always opens a fresh mesh and marks the block finalised
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FSCALE) |=> (!seen_ff && fin_ff))
      else $error("finalise left box state behind");

   // the output register is only loaded when free
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && rsp_stall) |=> (state_ff == S_OUT))
      else $error("result dropped while output stalled");

   // unused code kept out of the state vector
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_NONE + 4'd9))
      else $error("sequencer in an undefined state");

endmodule

// ----- dv/mbn_checker.sv -----
`timescale 1ns / 1ps
// Checker: predicts normaliser results from accepted items and compares them at the output.
module mbn_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  mbn_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  mbn_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               outstanding
);
   import mbn_pkg::*;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   localparam longint unsigned SCALE_TOP = 64'hFFFF_FFFF;
   localparam longint unsigned MAG_TOP   = 64'h8000_0000;

   // running box, last finalised box and scale
   longint          box_lo [3];
   longint          box_hi [3];
   bit              any_vertex;
   longint          centre [3];
   longint unsigned scale_q;
   bit              have_box;

   rsp_type expected_results [$];
   int      fail_count = 0;

   task automatic flag(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic longint clamp32(input longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // offset times scale, rounded on the magnitude, saturated
   function automatic longint apply_scale(input longint d, input longint unsigned s);
      longint unsigned mag, p, q;
      mag = (d < 0) ? -d : d;
      p   = mag * s;
      q   = (p >> FRAC_BITS) + ((p >> (FRAC_BITS - 1)) & 64'd1);
      if (q > MAG_TOP) q = MAG_TOP;
      return clamp32((d < 0) ? -longint'(q) : longint'(q));
   endfunction

   task automatic normalise_item(input req_type r);
      longint          v [3];
      longint unsigned w, h, span, num, den, q, mag;
      longint          res;
      int              ax;
      rsp_type         e;
      v[0] = longint'(r.x_in);
      v[1] = longint'(r.y_in);
      v[2] = longint'(r.z_in);
      ax   = (r.axis > AXIS_Z) ? int'(AXIS_Z) : int'(r.axis);
      e    = '0;
      case (r.op)
         OP_MEASURE: begin
            for (int k = 0; k < 3; k++) begin
               if (!any_vertex || v[k] < box_lo[k]) box_lo[k] = v[k];
               if (!any_vertex || v[k] > box_hi[k]) box_hi[k] = v[k];
            end
            any_vertex = 1'b1;
            return;
         end
         OP_FINALIZE: begin
            e.kind = KIND_FIN;
            if (!any_vertex) begin
               for (int k = 0; k < 3; k++) centre[k] = 0;
               scale_q  = SCALE_TOP;
               e.status = STAT_EMPTY;
            end else begin
               w = box_hi[0] - box_lo[0];
               h = box_hi[1] - box_lo[1];
               for (int k = 0; k < 3; k++) centre[k] = (box_lo[k] + box_hi[k]) >>> 1;
               span = (w > h) ? w : h;
               if (span == 0) begin
                  scale_q  = SCALE_TOP;
                  e.status = STAT_ZERO_SPAN;
               end else begin
                  num      = 64'd19 << (2 * FRAC_BITS);
                  den      = 64'd10 * span;
                  q        = (num + den / 2) / den;
                  scale_q  = (q > SCALE_TOP) ? SCALE_TOP : q;
                  e.status = STAT_OK;
               end
            end
            have_box   = 1'b1;
            any_vertex = 1'b0;
            for (int k = 0; k < 3; k++) begin
               box_lo[k] = 0;
               box_hi[k] = 0;
            end
            e.out_x     = 32'(centre[0]);
            e.out_y     = 32'(centre[1]);
            e.out_z     = 32'(centre[2]);
            e.scale_out = 32'(scale_q);
         end
         default: begin
            e.kind = (r.op == OP_TRANSFORM) ? KIND_XFORM : KIND_DENORM;
            if (!have_box) begin
               e.status = STAT_NOT_FIN;
            end else begin
               e.scale_out = 32'(scale_q);
               e.status    = STAT_OK;
               if (r.op == OP_TRANSFORM) begin
                  e.out_x = 32'(apply_scale(v[0] - centre[0], scale_q));
                  e.out_y = 32'(apply_scale(v[1] - centre[1], scale_q));
                  e.out_z = 32'(apply_scale(v[2] - centre[2], scale_q));
               end else begin
                  if (scale_q == 0) begin
                     if (v[0] > 0)      res = SAT_HI;
                     else if (v[0] < 0) res = SAT_LO;
                     else               res = centre[ax];
                  end else begin
                     mag = (v[0] < 0) ? -v[0] : v[0];
                     num = mag << FRAC_BITS;
                     q   = (num + scale_q / 2) / scale_q;
                     res = clamp32(((v[0] < 0) ? -longint'(q) : longint'(q)) + centre[ax]);
                  end
                  e.out_x = 32'(res);
               end
            end
         end
      endcase
      expected_results.push_back(e);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) flag($sformatf("%s: got %h, want %h", name, got, want));
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         flag($sformatf("result with nothing expected: %h", got));
         return;
      end
      want = expected_results.pop_front();
      compare_field("kind",      32'(got.kind),   32'(want.kind));
      compare_field("out_x",     got.out_x,       want.out_x);
      compare_field("out_y",     got.out_y,       want.out_y);
      compare_field("out_z",     got.out_z,       want.out_z);
      compare_field("scale_out", got.scale_out,   want.scale_out);
      compare_field("status",    32'(got.status), 32'(want.status));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            box_lo[k] = 0;
            box_hi[k] = 0;
            centre[k] = 0;
         end
         any_vertex = 1'b0;
         have_box   = 1'b0;
         scale_q    = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (req_valid && !req_stall) normalise_item(req_data);
      end
      mismatches  <= fail_count;
      outstanding <= expected_results.size();
   end

endmodule

// ----- dv/mesh_bbox_normalizer_tb.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, directed and random item stimulus, verdict for the normaliser.
module mesh_bbox_normalizer_tb;
   import mbn_pkg::*;

   localparam int ITEM_TARGET  = 1100;          // items before the stimulus stops
   localparam int QUIET_ITEMS  = 150;           // closing stretch without idling
   localparam int DRAIN_CYCLES = 2 * DIV_W + 20; // covers a trailing finalise or denormalise
   localparam logic [1:0] AXIS_BEYOND = 2'd3;   // out-of-range axis, folds onto z
   localparam logic signed [31:0] ONE_Q = 32'sd65536;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int mismatches;
   int outstanding;
   int items_sent = 0;
   int idle_pct   = 20;   // chance of an idle burst, percent
   bit quiet      = 1'b0; // no idling on either side once set

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mesh_bbox_normalizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   mbn_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   function automatic req_type make_item(input logic [1:0] op, input logic signed [31:0] x,
                                         input logic signed [31:0] y,
                                         input logic signed [31:0] z, input logic [1:0] axis);
      req_type r;
      r.op   = op;
      r.x_in = x;
      r.y_in = y;
      r.z_in = z;
      r.axis = axis;
      return r;
   endfunction

   // extremes, values near zero, or anything at all
   function automatic logic signed [31:0] any_coord();
      case ($urandom_range(0, 5))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2:       return '0;
         3:       return 32'($urandom_range(0, 4)) - 32'd2;
         default: return $urandom;
      endcase
   endfunction

   // a point inside a mesh's box, now and then a stray one
   function automatic logic signed [31:0] box_coord(input logic [31:0] base,
                                                    input logic [31:0] mask);
      if ($urandom_range(0, 15) == 0) return any_coord();
      return base + (32'($urandom) & mask);
   endfunction

   function automatic logic signed [31:0] denorm_coord();
      if ($urandom_range(0, 2) != 0) return 32'($signed($urandom_range(0, 262144)) - 131072);
      return any_coord();
   endfunction

   // Holds the item until accepted, then maybe lowers valid for a burst.
   // Valid is only lowered after a handshake, so a stalled item never changes.
   task automatic push_item(input req_type r);
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (!quiet && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // One well-formed mesh: measure, finalise, then use the box.
   task automatic run_mesh();
      logic [31:0] base [3];
      logic [31:0] mask [3];
      int          n_vert;
      int          n_use;
      int          span_bits;
      req_type     r;
      for (int k = 0; k < 3; k++) begin
         span_bits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : $urandom_range(4, 20);
         mask[k]   = 32'((64'd1 << span_bits) - 64'd1);
         base[k]   = $urandom_range(0, 1) ? $urandom : -(mask[k] >> 1);
      end
      // now and then an empty mesh
      n_vert = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
      repeat (n_vert)
         push_item(make_item(OP_MEASURE, box_coord(base[0], mask[0]),
                             box_coord(base[1], mask[1]), box_coord(base[2], mask[2]),
                             2'($urandom_range(0, 3))));
      push_item(make_item(OP_FINALIZE, $urandom, $urandom, $urandom, 2'($urandom_range(0, 3))));
      n_use = $urandom_range(1, 8);
      repeat (n_use) begin
         if ($urandom_range(0, 1) == 0)
            r = make_item(OP_TRANSFORM, box_coord(base[0], mask[0]),
                          box_coord(base[1], mask[1]), box_coord(base[2], mask[2]),
                          2'($urandom_range(0, 3)));
         else
            r = make_item(OP_DENORM, denorm_coord(), $urandom, $urandom,
                          2'($urandom_range(0, 3)));
         push_item(r);
      end
   endtask

   // Receiver: random stall bursts, none once quiet.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 99) < idle_pct / 3) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int segment;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // use before any finalise: not finalised
      push_item(make_item(OP_TRANSFORM, 32'sd1, 32'sd2, 32'sd3, AXIS_X));
      push_item(make_item(OP_DENORM, -32'sd5, '0, '0, AXIS_BEYOND));
      // empty mesh, then use the saturated scale at the extremes
      push_item(make_item(OP_FINALIZE, '0, '0, '0, AXIS_X));
      push_item(make_item(OP_TRANSFORM, Q_MAX, Q_MIN, '0, AXIS_X));
      push_item(make_item(OP_DENORM, Q_MIN, '0, '0, AXIS_X));
      // single vertex: zero span keeps its centre
      push_item(make_item(OP_MEASURE, 32'sd100, 32'sd200, 32'sd300, AXIS_X));
      push_item(make_item(OP_FINALIZE, '0, '0, '0, AXIS_X));
      push_item(make_item(OP_DENORM, '0, '0, '0, AXIS_Y));
      // span of one lsb: scale saturates
      push_item(make_item(OP_MEASURE, '0, '0, '0, AXIS_X));
      push_item(make_item(OP_MEASURE, 32'sd1, '0, 32'sd5, AXIS_X));
      push_item(make_item(OP_FINALIZE, '0, '0, '0, AXIS_X));
      // widest possible box
      push_item(make_item(OP_MEASURE, Q_MIN, Q_MIN, Q_MIN, AXIS_X));
      push_item(make_item(OP_MEASURE, Q_MAX, Q_MAX, Q_MAX, AXIS_X));
      push_item(make_item(OP_FINALIZE, '0, '0, '0, AXIS_X));
      push_item(make_item(OP_TRANSFORM, Q_MAX, Q_MIN, Q_MAX, AXIS_X));
      push_item(make_item(OP_DENORM, Q_MAX, '0, '0, AXIS_X));
      push_item(make_item(OP_DENORM, Q_MIN, '0, '0, AXIS_BEYOND));
      push_item(make_item(OP_DENORM, ONE_Q, '0, '0, AXIS_Z));
      // width decides; a transform mid-measure still uses the previous box
      push_item(make_item(OP_MEASURE, '0, '0, '0, AXIS_X));
      push_item(make_item(OP_TRANSFORM, ONE_Q, -ONE_Q, '0, AXIS_X));
      push_item(make_item(OP_MEASURE, 2 * ONE_Q, ONE_Q, 7 * ONE_Q, AXIS_X));
      push_item(make_item(OP_FINALIZE, '0, '0, '0, AXIS_X));
      // height decides
      push_item(make_item(OP_MEASURE, -ONE_Q, -3 * ONE_Q, '0, AXIS_X));
      push_item(make_item(OP_MEASURE, '0, 3 * ONE_Q, '0, AXIS_X));
      push_item(make_item(OP_FINALIZE, '0, '0, '0, AXIS_X));
      push_item(make_item(OP_TRANSFORM, '0, 3 * ONE_Q, -ONE_Q, AXIS_X));

      // --- random: mostly whole meshes, some loose items of any kind ---
      segment = -1;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - QUIET_ITEMS) begin
            quiet    = 1'b1;
            idle_pct = 0;
         end else if (items_sent / 100 != segment) begin
            segment = items_sent / 100;
            case ($urandom_range(0, 3))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               2:       idle_pct = 30;
               default: idle_pct = 60;
            endcase
         end
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
               push_item(make_item(2'($urandom_range(0, 3)), any_coord(), any_coord(),
                                   any_coord(), 2'($urandom_range(0, 3))));
         else
            run_mesh();
      end

      // drain: let the checker's count settle, then allow for a trailing item
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("mesh_bbox_normalizer verification clean");
      else
         $display("mesh_bbox_normalizer verification failed");
      $finish;
   end

   // watchdog, well above the slowest correct run
   initial begin
      #8_000_000;
      $display("mesh_bbox_normalizer verification failed");
      $finish;
   end

endmodule
